/* rtl/line_sensor_ring_detector_top_defines.svh */
// ----------------------------------------------------------------------------
// Line sensor ring detector - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_RING_DETECTOR_TOP_DEFINES_SVH
`define LINE_SENSOR_RING_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define LSRD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define LSRD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LSRD_ASSERT(label, clk, rst, prop, msg)

`define LSRD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/lsrd_pkg.sv */
// ----------------------------------------------------------------------------
// Line sensor ring detector package
// Payload types, opcodes and defaults shared by the interfaces and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsrd_pkg;

   localparam int SENSOR_COUNT_DEF = 32;
   localparam int SAMPLE_BITS_DEF  = 10;

   localparam logic [15:0] SENS_RESET    = 16'd19661;  // 0.30 in Q0.16
   localparam int          MIN_LEVEL_CAP = 999;
   localparam logic [5:0]  COUNT_MAX     = 6'd63;
   localparam int          ANGLE_OFFSET  = 270;        // -90 mod 360
   localparam int          FULL_CIRCLE   = 360;

   typedef enum logic [1:0] {
      OP_DETECT    = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_CLR_HIST  = 2'd2,
      OP_CLR_THR   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type opcode;
      logic [4:0] sensor_index;
      logic [9:0] reading;
      logic       scan_last;
   } req_payload_type;

   typedef struct packed {
      logic       sample_white;
      logic [9:0] threshold_now;
      logic       scan_done;
      logic [5:0] white_count;
      logic [5:0] history_count;
      logic       touching;
      logic       new_touch;
      logic [4:0] first_index;
      logic [8:0] first_angle;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/lsrd_if.sv */
// ----------------------------------------------------------------------------
// Line sensor ring detector channels
// Valid/ready channels for sample requests and per-item responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsrd_req_if;
   logic                     valid;
   logic                     ready;
   lsrd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lsrd_rsp_if;
   logic                     valid;
   logic                     ready;
   lsrd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/line_sensor_ring_detector_top.sv */
// ----------------------------------------------------------------------------
// Line sensor ring detector
// Per-sensor min/max calibration, threshold detect and scan summary.
// ----------------------------------------------------------------------------
// Takes one sample transfer per clock while the response side is not stalled
// and returns exactly one response per sample. A sample sits in the input
// register while its result is computed; its response then waits for the
// response side to take it from the
// result register. Per-sensor min, max, threshold and history live in
// flip-flops indexed by sensor_index, so back-to-back samples of the same
// sensor see each other's updates. The cycle path is the calibrate update:
// min/max compare, span subtract, one span x sensitivity multiply and the add
// to min. The sensitivity register should be written only while no transfer
// is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "line_sensor_ring_detector_top_defines.svh"

module line_sensor_ring_detector_top #(
   parameter int SENSOR_COUNT = lsrd_pkg::SENSOR_COUNT_DEF,
   parameter int SAMPLE_BITS  = lsrd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lsrd_req_if.sink         req_chan,
   lsrd_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import lsrd_pkg::*;

   localparam int IDX_W       = $clog2(SENSOR_COUNT);
   localparam int SAMPLE_MASK = (1 << SAMPLE_BITS) - 1;
   localparam int MIN_RESET   = (MIN_LEVEL_CAP < SAMPLE_MASK) ? MIN_LEVEL_CAP : SAMPLE_MASK;
   localparam int ANGLE_STEP  = FULL_CIRCLE / SENSOR_COUNT;
   localparam int PROD_W      = SAMPLE_BITS + 16;

   typedef logic [SAMPLE_BITS-1:0] level_type;

   // registers
   logic [15:0]     sens_ff;
   logic            s1_valid_ff;
   req_payload_type s1_payload_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   level_type       min_ff [SENSOR_COUNT];
   level_type       max_ff [SENSOR_COUNT];
   level_type       thr_ff [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] hist_ff;

   logic            was_touch_ff, was_touch_in;
   logic [4:0]      held_ff, held_in;
   logic [5:0]      white_acc_ff, white_acc_in;
   logic [5:0]      hist_acc_ff, hist_acc_in;
   logic            any_white_ff, any_white_in;
   logic            first_hit_ff, first_hit_in;

   // per-item combinational values
   logic            out_ready, advance, req_ready;
   logic [6:0]      idx_ext;
   logic [IDX_W-1:0] idx;
   logic            in_ring;
   logic [15:0]     rd_ext;
   level_type       rd, min_new, max_new, span, thr_cal, thr_now;
   logic [PROD_W-1:0] prod;
   logic [15:0]     thr_ext;
   logic            white, hist_after, upd_held, is_detect, touch;
   logic [4:0]      held_next, held_out;
   logic [8:0]      angle_lut [32];

   for (genvar g = 0; g < 32; g++) begin : g_angle
      assign angle_lut[g] = 9'((g * ANGLE_STEP + ANGLE_OFFSET) % FULL_CIRCLE);
   end

   assign out_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = s1_valid_ff && out_ready;
   assign req_ready = !s1_valid_ff || out_ready;

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // stage 1 decode
   assign idx_ext = {2'b00, s1_payload_ff.sensor_index};
   assign idx     = idx_ext[IDX_W-1:0];
   assign in_ring = ({25'd0, idx_ext} < 32'(SENSOR_COUNT));
   assign rd_ext  = {6'd0, s1_payload_ff.reading};
   assign rd      = rd_ext[SAMPLE_BITS-1:0];

   // calibrate datapath
   always_comb begin
      max_new = (rd > max_ff[idx]) ? rd : max_ff[idx];
      min_new = (rd < min_ff[idx]) ? rd : min_ff[idx];
      span    = (max_new >= min_new) ? (max_new - min_new) : '0;
      prod    = PROD_W'(span) * PROD_W'(sens_ff);
      thr_cal = min_new + prod[PROD_W-1:16];
   end

   // detect and scan summary
   always_comb begin
      is_detect    = (s1_payload_ff.opcode == OP_DETECT);
      white        = is_detect && in_ring && (rd > thr_ff[idx]);
      hist_after   = in_ring && (hist_ff[idx] || white);
      upd_held     = white && !was_touch_ff &&
                     (!first_hit_ff || (s1_payload_ff.sensor_index < held_ff));
      held_next    = upd_held ? s1_payload_ff.sensor_index : held_ff;
      touch        = any_white_ff || white;
      held_out     = touch ? held_next : 5'd0;

      white_acc_in = white_acc_ff;
      hist_acc_in  = hist_acc_ff;
      any_white_in = any_white_ff;
      first_hit_in = first_hit_ff;
      held_in      = held_ff;
      was_touch_in = was_touch_ff;

      case (s1_payload_ff.opcode)
         OP_DETECT: begin
            if (white) begin
               white_acc_in = (white_acc_ff == COUNT_MAX) ? COUNT_MAX : white_acc_ff + 6'd1;
               any_white_in = 1'b1;
            end
            if (upd_held) begin
               held_in      = held_next;
               first_hit_in = 1'b1;
            end
            if (is_detect && hist_after) begin
               hist_acc_in = (hist_acc_ff == COUNT_MAX) ? COUNT_MAX : hist_acc_ff + 6'd1;
            end
         end
         OP_CLR_HIST: begin
            hist_acc_in = '0;
         end
         default: begin
         end
      endcase

      case (s1_payload_ff.opcode)
         OP_CALIBRATE: thr_now = thr_cal;
         OP_CLR_THR:   thr_now = '0;
         default:      thr_now = thr_ff[idx];
      endcase
      thr_ext = in_ring ? 16'(thr_now) : 16'd0;

      rsp_payload_in               = '0;
      rsp_payload_in.sample_white  = white;
      rsp_payload_in.threshold_now = thr_ext[9:0];

      if (is_detect && s1_payload_ff.scan_last) begin
         rsp_payload_in.scan_done     = 1'b1;
         rsp_payload_in.white_count   = white_acc_in;
         rsp_payload_in.history_count = hist_acc_in;
         rsp_payload_in.touching      = touch;
         rsp_payload_in.new_touch     = touch && !was_touch_ff;
         rsp_payload_in.first_index   = held_out;
         rsp_payload_in.first_angle   = touch ? angle_lut[held_out] : 9'd0;
         held_in      = held_out;
         was_touch_in = touch;
         white_acc_in = '0;
         hist_acc_in  = '0;
         any_white_in = 1'b0;
         first_hit_in = 1'b0;
      end
   end

   // handshake stages and config
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sens_ff      <= SENS_RESET;
      end else begin
         if (csr_wr_en) begin
            sens_ff <= csr_wr_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         s1_payload_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // sensor and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            min_ff[i] <= level_type'(MIN_RESET);
            max_ff[i] <= '0;
            thr_ff[i] <= '0;
         end
         hist_ff      <= '0;
         was_touch_ff <= 1'b0;
         held_ff      <= '0;
         white_acc_ff <= '0;
         hist_acc_ff  <= '0;
         any_white_ff <= 1'b0;
         first_hit_ff <= 1'b0;
      end else if (advance) begin
         was_touch_ff <= was_touch_in;
         held_ff      <= held_in;
         white_acc_ff <= white_acc_in;
         hist_acc_ff  <= hist_acc_in;
         any_white_ff <= any_white_in;
         first_hit_ff <= first_hit_in;
         case (s1_payload_ff.opcode)
            OP_CALIBRATE: begin
               if (in_ring) begin
                  min_ff[idx] <= min_new;
                  max_ff[idx] <= max_new;
                  thr_ff[idx] <= thr_cal;
               end
            end
            OP_CLR_HIST: begin
               hist_ff <= '0;
            end
            OP_CLR_THR: begin
               for (int i = 0; i < SENSOR_COUNT; i++) begin
                  thr_ff[i] <= '0;
               end
            end
            default: begin
               if (white) begin
                  hist_ff[idx] <= 1'b1;
               end
            end
         endcase
      end
   end

   `LSRD_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !s1_valid_ff && !rsp_valid_ff,
      "pipeline not empty after reset")

   `LSRD_ASSERT(a_advance_fills, clock, reset,
      advance |=> rsp_valid_ff,
      "stage 1 item lost on advance")

   `LSRD_ASSERT(a_no_summary, clock, reset,
      rsp_valid_ff && !rsp_payload_ff.scan_done |->
         rsp_payload_ff.white_count == 6'd0 && rsp_payload_ff.history_count == 6'd0 &&
         !rsp_payload_ff.touching && !rsp_payload_ff.new_touch,
      "summary fields set without scan end")

   `LSRD_ASSERT(a_touch_fields, clock, reset,
      rsp_valid_ff && !rsp_payload_ff.touching |->
         !rsp_payload_ff.new_touch && rsp_payload_ff.first_index == 5'd0 &&
         rsp_payload_ff.first_angle == 9'd0,
      "touch fields set without touch")

   `LSRD_ASSERT(a_angle_range, clock, reset,
      rsp_valid_ff |-> rsp_payload_ff.first_angle < 9'(FULL_CIRCLE),
      "angle out of range")

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor ring detector testbench
// Drives sample transfers (detect, calibrate, clear history, clear thresholds)
// through the request channel and checks every response against a predictor
// of the per-sensor min/max/threshold state and the scan summary. Covers
// directed corner cases, full and broken scans, calibration sweeps, counter
// saturation and several sensitivity settings, under random idling on both
// sides and a long response stall.
// ----------------------------------------------------------------------------

module tb;
   import lsrd_pkg::*;

   localparam int RING           = SENSOR_COUNT_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 120;

   class ring_scoreboard;
      bit [9:0]        min_lv [RING];
      bit [9:0]        max_lv [RING];
      bit [9:0]        thr    [RING];
      bit              hist   [RING];
      bit              was_touch;
      bit [4:0]        held;
      bit [5:0]        white_acc;
      bit [5:0]        hist_acc;
      bit              any_white;
      bit              first_hit;
      bit [15:0]       sens;
      rsp_payload_type expected_q [$];
      int              errors;

      function new();
         errors = 0;
         sens   = SENS_RESET;
         for (int i = 0; i < RING; i++) begin
            min_lv[i] = 10'(MIN_LEVEL_CAP);
            max_lv[i] = '0;
            thr[i]    = '0;
            hist[i]   = 1'b0;
         end
         was_touch = 1'b0;
         held      = '0;
         white_acc = '0;
         hist_acc  = '0;
         any_white = 1'b0;
         first_hit = 1'b0;
      endfunction

      function bit [5:0] sat_inc(bit [5:0] v);
         return (v == COUNT_MAX) ? v : v + 6'd1;
      endfunction

      function void note_input(req_payload_type p);
         rsp_payload_type e;
         int unsigned     span;
         bit [4:0]        idx;
         bit [9:0]        rd;
         bit              white;
         bit              touch;
         e     = '0;
         idx   = p.sensor_index;
         rd    = p.reading;
         white = 1'b0;
         case (p.opcode)
            OP_CALIBRATE: begin
               if (rd > max_lv[idx]) max_lv[idx] = rd;
               if (rd < min_lv[idx]) min_lv[idx] = rd;
               span = (max_lv[idx] >= min_lv[idx]) ? max_lv[idx] - min_lv[idx] : 0;
               thr[idx] = 10'(min_lv[idx] + ((span * sens) >> 16));
            end
            OP_CLR_HIST: begin
               for (int i = 0; i < RING; i++) hist[i] = 1'b0;
               hist_acc = '0;
            end
            OP_CLR_THR: begin
               for (int i = 0; i < RING; i++) thr[i] = '0;
            end
            default: begin
               white = rd > thr[idx];
               if (white) begin
                  hist[idx] = 1'b1;
                  white_acc = sat_inc(white_acc);
                  any_white = 1'b1;
                  if (!was_touch && (!first_hit || idx < held)) begin
                     held      = idx;
                     first_hit = 1'b1;
                  end
               end
               if (hist[idx]) hist_acc = sat_inc(hist_acc);
               if (p.scan_last) begin
                  touch           = any_white;
                  e.scan_done     = 1'b1;
                  e.white_count   = white_acc;
                  e.history_count = hist_acc;
                  e.touching      = touch;
                  e.new_touch     = touch && !was_touch;
                  if (!touch) held = '0;
                  e.first_index   = held;
                  e.first_angle   = touch ?
                     9'((int'(held) * (FULL_CIRCLE / RING) + ANGLE_OFFSET) % FULL_CIRCLE) : '0;
                  was_touch = touch;
                  white_acc = '0;
                  hist_acc  = '0;
                  any_white = 1'b0;
                  first_hit = 1'b0;
               end
            end
         endcase
         e.sample_white  = white;
         e.threshold_now = thr[idx];
         expected_q.push_back(e);
      endfunction

      function void cmp(string field, logic [15:0] e, logic [15:0] a);
         if (e !== a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type r);
         rsp_payload_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no sample pending, expected none, got %h", $time, r);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp("sample_white",  16'(e.sample_white),  16'(r.sample_white));
         cmp("threshold_now", 16'(e.threshold_now), 16'(r.threshold_now));
         cmp("scan_done",     16'(e.scan_done),     16'(r.scan_done));
         cmp("white_count",   16'(e.white_count),   16'(r.white_count));
         cmp("history_count", 16'(e.history_count), 16'(r.history_count));
         cmp("touching",      16'(e.touching),      16'(r.touching));
         cmp("new_touch",     16'(e.new_touch),     16'(r.new_touch));
         cmp("first_index",   16'(e.first_index),   16'(r.first_index));
         cmp("first_angle",   16'(e.first_angle),   16'(r.first_angle));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   bit          hold_req    = 1'b0;
   int          idle_cycles = 0;
   int          items_sent  = 0;

   ring_scoreboard sb = new();

   lsrd_req_if req_if ();
   lsrd_rsp_if rsp_if ();

   line_sensor_ring_detector_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_input(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_req(opcode_type op, bit [4:0] idx, bit [9:0] rd, bit last);
      req_payload_type p;
      p.opcode       = op;
      p.sensor_index = idx;
      p.reading      = rd;
      p.scan_last    = last;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.payload <= p;
      req_if.valid   <= 1'b1;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   function automatic bit [9:0] pick_reading(int mode, bit [9:0] t);
      int v;
      case (mode)
         0: return 10'($urandom_range(t));
         1: begin
            v = int'(t) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            return 10'(v);
         end
         2: return 10'($urandom_range(1023));
         default: return ($urandom_range(7) == 0) ? 10'd1023 : 10'($urandom_range(t));
      endcase
   endfunction

   // wait until every transfer has its response, then let the pipe settle
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sensitivity(bit [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.sens = v;
      @(posedge clock);
   endtask

   // enough white samples in one scan to saturate both counters
   task automatic long_scan();
      for (int k = 0; k < 70; k++)
         send_req(OP_DETECT, 5'(k % RING), 10'd1023, k == 69);
   endtask

   task automatic run_random(int goal);
      int       r;
      int       mode;
      int       n;
      bit [9:0] base;
      bit [9:0] spread;
      while (items_sent < goal) begin
         r = $urandom_range(99);
         if (r < 50) begin
            mode = $urandom_range(3);
            for (int i = 0; i < RING; i++)
               send_req(OP_DETECT, 5'(i), pick_reading(mode, sb.thr[i]), i == RING - 1);
         end else if (r < 65) begin
            base   = 10'($urandom_range(800));
            spread = 10'($urandom_range(223));
            for (int i = 0; i < RING; i++)
               send_req(OP_CALIBRATE, 5'(i), base + 10'($urandom_range(spread)),
                        1'($urandom_range(1)));
         end else if (r < 80) begin
            n = $urandom_range(40, 1);
            for (int i = 0; i < n; i++) begin
               base = 10'($urandom_range(RING - 1));
               send_req(OP_DETECT, 5'(base), pick_reading($urandom_range(3), sb.thr[base]),
                        $urandom_range(15) == 0);
            end
         end else if (r < 93) begin
            send_req(opcode_type'($urandom_range(3)), 5'($urandom_range(31)),
                     10'($urandom_range(1023)), 1'($urandom_range(1)));
         end else begin
            send_req(($urandom_range(1) == 0) ? OP_CLR_HIST : OP_CLR_THR,
                     5'($urandom_range(31)), 10'($urandom_range(1023)),
                     1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(OP_DETECT,    5'd0,  10'd0,    1'b0);
      send_req(OP_DETECT,    5'd31, 10'd1023, 1'b1);
      send_req(OP_DETECT,    5'd0,  10'd0,    1'b1);
      send_req(OP_CALIBRATE, 5'd5,  10'd0,    1'b1);
      send_req(OP_CALIBRATE, 5'd5,  10'd1023, 1'b0);
      send_req(OP_CALIBRATE, 5'd6,  10'd1023, 1'b0);
      send_req(OP_DETECT,    5'd5,  10'd306,  1'b0);
      send_req(OP_DETECT,    5'd5,  10'd307,  1'b0);
      send_req(OP_DETECT,    5'd6,  10'd1023, 1'b0);
      send_req(OP_DETECT,    5'd1,  10'd1,    1'b0);
      send_req(OP_CLR_HIST,  5'd0,  10'd0,    1'b1);
      send_req(OP_DETECT,    5'd2,  10'd5,    1'b1);
      send_req(OP_DETECT,    5'd31, 10'd0,    1'b1);
      send_req(OP_CLR_THR,   5'd9,  10'd1023, 1'b1);
      send_req(OP_DETECT,    5'd6,  10'd1,    1'b1);
      send_req(OP_DETECT,    5'd3,  10'd700,  1'b0);
      send_req(OP_DETECT,    5'd31, 10'd1023, 1'b1);
      send_req(OP_CALIBRATE, 5'd31, 10'd1023, 1'b0);
      send_req(OP_CALIBRATE, 5'd31, 10'd0,    1'b0);
      send_req(OP_DETECT,    5'd31, 10'd1023, 1'b1);
      settle();

      write_sensitivity(16'hFFFF);
      tx_idle_pct = 26;
      rx_idle_pct = 47;
      long_scan();
      run_random(330);
      settle();

      write_sensitivity(16'h0000);
      tx_idle_pct = 47;
      rx_idle_pct = 26;
      long_scan();
      run_random(650);
      settle();

      write_sensitivity(16'($urandom_range(65535)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req    = 1'b1;
      long_scan();
      run_random(800);
      settle();
      run_random(970);
      settle();
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
